// ----- rtl/lcgub_pkg.sv -----
// shared types and constants of the lcg uniform and binomial draw core
package lcgub_pkg;

  localparam logic [31:0] LcgMul = 32'd1103515245;
  localparam logic [31:0] LcgAdd = 32'd12345;
  localparam int unsigned UniShift = 16;
  localparam int unsigned BinomBit = 30;

  typedef enum logic [1:0] {
    OP_UNIFORM  = 2'd0,
    OP_BINOMIAL = 2'd1,
    OP_RESEED   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UNI,
    ST_BIN,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    SEL_UNI,
    SEL_BIN,
    SEL_FIN
  } emit_sel_e;

  typedef struct packed {
    op_e         opcode;
    logic [15:0] range;
    logic [31:0] new_seed;
  } in_item_t;

  typedef struct packed {
    logic [15:0] value;
    logic [31:0] seed_after;
    logic [31:0] call_count;
    logic [31:0] reseed_count;
  } out_item_t;

  typedef struct packed {
    logic      load;
    logic      iter;
    logic      emit;
    emit_sel_e sel;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  in_op;
    logic in_bin_run;
    logic cnt_zero;
  } dp_status_t;

endpackage

// ----- rtl/lcgub_ctrl.sv -----
// controller state machine of the lcg draw core
module lcgub_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  lcgub_pkg::dp_status_t status_i,
  output lcgub_pkg::ctrl_cmd_t  cmd_o
);

  lcgub_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lcgub_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          priority case (status_i.in_op)
            lcgub_pkg::OP_UNIFORM:  state_d = lcgub_pkg::ST_UNI;
            lcgub_pkg::OP_BINOMIAL: begin
              state_d = status_i.in_bin_run ? lcgub_pkg::ST_BIN : lcgub_pkg::ST_FIN;
            end
            default:                state_d = lcgub_pkg::ST_FIN;
          endcase
        end
      end
      lcgub_pkg::ST_UNI: begin
        if (out_free) state_d = lcgub_pkg::ST_IDLE;
      end
      lcgub_pkg::ST_BIN: begin
        if (status_i.cnt_zero && out_free) state_d = lcgub_pkg::ST_IDLE;
      end
      lcgub_pkg::ST_FIN: begin
        if (out_free) state_d = lcgub_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '{load: 1'b0, iter: 1'b0, emit: 1'b0, sel: lcgub_pkg::SEL_FIN};
    unique case (state_q)
      lcgub_pkg::ST_IDLE: cmd_o.load = in_valid_i;
      lcgub_pkg::ST_UNI: begin
        cmd_o.sel  = lcgub_pkg::SEL_UNI;
        cmd_o.emit = out_free;
      end
      lcgub_pkg::ST_BIN: begin
        cmd_o.sel  = lcgub_pkg::SEL_BIN;
        cmd_o.iter = !status_i.cnt_zero;
        cmd_o.emit = status_i.cnt_zero && out_free;
      end
      lcgub_pkg::ST_FIN: begin
        cmd_o.sel  = lcgub_pkg::SEL_FIN;
        cmd_o.emit = out_free;
      end
    endcase
  end

  assign out_valid_d = cmd_o.emit || (out_valid_q && out_stall_i);
  assign out_valid_o = out_valid_q;
  assign in_stall_o  = (state_q != lcgub_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcgub_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q)
    else $error("result not presented after emit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q != lcgub_pkg::ST_IDLE))
    else $error("accepted item left no work");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lcgub_pkg::ST_BIN) && !status_i.cnt_zero |=> (state_q == lcgub_pkg::ST_BIN))
    else $error("binomial loop left early");

endmodule

// ----- rtl/lcgub_dp.sv -----
// datapath of the lcg draw core: seed, counters, shared multiplier, result register
module lcgub_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  lcgub_pkg::in_item_t   in_item_i,
  input  lcgub_pkg::ctrl_cmd_t  cmd_i,
  output lcgub_pkg::dp_status_t status_o,
  output lcgub_pkg::out_item_t  out_item_o
);

  logic [31:0] seed_q, seed_d;
  logic [31:0] draws_q, draws_d;
  logic [31:0] reseeds_q, reseeds_d;
  logic [31:0] x_q;
  logic [15:0] cnt_q;
  logic [15:0] acc_q;
  logic [15:0] range_q;
  logic [31:0] new_seed_q;
  lcgub_pkg::op_e op_q;
  lcgub_pkg::out_item_t out_q;

  logic [31:0] mul_a;
  logic [31:0] mul_lo;
  logic [31:0] step;
  logic [31:0] uni_prod;
  logic [15:0] value;

  assign mul_a  = cmd_i.load ? seed_q : x_q;
  assign mul_lo = mul_a * lcgub_pkg::LcgMul;
  assign step   = mul_lo + lcgub_pkg::LcgAdd;

  assign uni_prod = {16'b0, x_q[31:lcgub_pkg::UniShift]} * {16'b0, range_q};

  assign status_o.in_op      = in_item_i.opcode;
  assign status_o.in_bin_run = (in_item_i.range > 16'd1);
  assign status_o.cnt_zero   = (cnt_q == 16'd0);

  always_comb begin
    seed_d    = seed_q;
    draws_d   = draws_q;
    reseeds_d = reseeds_q;
    value     = 16'd0;
    unique case (cmd_i.sel)
      lcgub_pkg::SEL_UNI: begin
        value   = uni_prod[31:16];
        seed_d  = x_q;
        draws_d = draws_q + 32'd1;
      end
      lcgub_pkg::SEL_BIN: begin
        value   = acc_q;
        seed_d  = x_q;
        draws_d = draws_q + {16'b0, range_q};
      end
      lcgub_pkg::SEL_FIN: begin
        if (op_q == lcgub_pkg::OP_RESEED) begin
          seed_d    = new_seed_q;
          reseeds_d = reseeds_q + 32'd1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q    <= 32'd0;
      draws_q   <= 32'd0;
      reseeds_q <= 32'd0;
    end else if (cmd_i.emit) begin
      seed_q    <= seed_d;
      draws_q   <= draws_d;
      reseeds_q <= reseeds_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q        <= step;
      cnt_q      <= in_item_i.range - 16'd1;
      acc_q      <= 16'd0;
      range_q    <= in_item_i.range;
      new_seed_q <= in_item_i.new_seed;
      op_q       <= in_item_i.opcode;
    end else if (cmd_i.iter) begin
      x_q   <= step;
      cnt_q <= cnt_q - 16'd1;
      acc_q <= acc_q + {15'b0, x_q[lcgub_pkg::BinomBit]};
    end
    if (cmd_i.emit) begin
      out_q <= '{value: value, seed_after: seed_d, call_count: draws_d,
                 reseed_count: reseeds_d};
    end
  end

  assign out_item_o = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit && (cmd_i.sel == lcgub_pkg::SEL_UNI) |=> (seed_q == $past(x_q)))
    else $error("uniform draw did not commit advanced seed");

endmodule

// ----- rtl/lcg_uniform_and_binomial_draw_core.sv -----
// top level of the lcg uniform and binomial draw core
//
//   channel  direction  payload      handshake
//   in       input      in_item_t    in_valid_i / in_stall_o
//   out      output     out_item_t   out_valid_o / out_stall_i
//
// uniform draw, reseed, unused opcode: load in idle, emit from uni or fin
// binomial draw with range r above 1: load, then one lcg step per cycle
// through the single shared 32x32 multiplier
// one item in flight; the next item is taken while the result register waits
// async active-low reset clears seed and both counters to zero
module lcg_uniform_and_binomial_draw_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lcgub_pkg::in_item_t  in_item_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output lcgub_pkg::out_item_t out_item_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i
);

  lcgub_pkg::ctrl_cmd_t  cmd;
  lcgub_pkg::dp_status_t status;

  lcgub_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  lcgub_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

endmodule
